@@ rtl/bcsr_pkg.sv @@
// Shared constants, types and helpers for the block sparse row packer.
package bcsr_pkg;

  localparam int MAX_BLOCK_ROWS = 8;
  localparam int MAX_BLOCK_COLS = 8;
  localparam int MAX_DIM        = 4096;

  localparam int LANE_W     = 8;
  localparam int NUM_LANES  = 8;
  localparam int LANE_IDX_W = $clog2(NUM_LANES);
  localparam int ROW_IDX_W  = (MAX_BLOCK_ROWS > 1) ? $clog2(MAX_BLOCK_ROWS) : 1;
  localparam int DIM_W      = 13;
  localparam int BLK_W      = 4;
  localparam int POS_W      = 12;
  localparam int PROD_W     = POS_W + BLK_W;
  localparam int CNT_W      = 25;
  localparam int ROW_W      = LANE_W * NUM_LANES;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 96;

  localparam logic [KIND_W-1:0] KIND_VALUE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PTR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ROWS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COLS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PER_TENSOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TENSOR_ZP   = 3'd5;

  typedef logic [LANE_W-1:0] lane_byte_t;

  // one block's worth of results handed to the emitter
  typedef struct packed {
    logic                 lead_ptr;   // leading zero pointer
    logic                 blk;        // value rows plus column index
    logic                 row_ptr;    // pointer at row-block end
    logic [BLK_W-1:0]     rows_here;  // rows holding data
    logic [BLK_W-1:0]     blk_rows;   // rows to emit
    logic [POS_W-1:0]     col_idx;
    logic [CNT_W-1:0]     ptr_val;
  } emit_req_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  function automatic logic [BLK_W-1:0] clamp_blk(input logic [BLK_W-1:0] v,
                                                 input logic [BLK_W-1:0] hi);
    if (v == '0) return BLK_W'(1);
    if (v > hi) return hi;
    return v;
  endfunction

endpackage

@@ rtl/bcsr_lane.sv @@
// One lane: range gating and zero-point compare for a single element.
module bcsr_lane (
  input  logic [bcsr_pkg::LANE_W-1:0]     lane_val,
  input  logic [bcsr_pkg::LANE_W-1:0]     zero_pt,
  input  logic [bcsr_pkg::PROD_W-1:0]     col_base,
  input  logic [bcsr_pkg::LANE_IDX_W-1:0] lane_idx,
  input  logic [bcsr_pkg::BLK_W-1:0]      blk_cols,
  input  logic [bcsr_pkg::DIM_W-1:0]      mat_cols,
  output logic [bcsr_pkg::LANE_W-1:0]     lane_out,
  output logic                            lane_nz
);

  logic in_range;

  assign in_range = ({1'b0, lane_idx} < (bcsr_pkg::LANE_IDX_W+1)'(blk_cols))
                 && (({1'b0, col_base} + (bcsr_pkg::PROD_W+1)'(lane_idx))
                     < (bcsr_pkg::PROD_W+1)'(mat_cols));

  assign lane_out = in_range ? lane_val : '0;
  assign lane_nz  = in_range && (lane_val != zero_pt);

endmodule

@@ rtl/bcsr_merge.sv @@
// Merge stage: packs lane bytes into a row word and ORs the nonzero flags.
module bcsr_merge (
  input  bcsr_pkg::lane_byte_t          lane_bytes [bcsr_pkg::NUM_LANES],
  input  logic                          lane_nz    [bcsr_pkg::NUM_LANES],
  output logic [bcsr_pkg::ROW_W-1:0]    row_word,
  output logic                          any_nz
);

  always_comb begin
    any_nz = 1'b0;
    for (int j = 0; j < bcsr_pkg::NUM_LANES; j++) begin
      row_word[j*bcsr_pkg::LANE_W +: bcsr_pkg::LANE_W] = lane_bytes[j];
      any_nz = any_nz | lane_nz[j];
    end
  end

endmodule

@@ rtl/bcsr_emit.sv @@
// Result sequencer and output register: pointer, value rows, column index.
module bcsr_emit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 req_load,
  input  bcsr_pkg::emit_req_t                  req,
  output logic                                 busy,
  output logic [bcsr_pkg::ROW_IDX_W-1:0]       buf_raddr,
  input  logic [bcsr_pkg::ROW_W-1:0]           buf_rdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bcsr_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [bcsr_pkg::KIND_W-1:0]          out_tuser,
  output logic                                 out_tlast
);

  logic                              lead_r, lead_nxt;
  logic                              rows_r, rows_nxt;
  logic                              col_r, col_nxt;
  logic                              ptr_r, ptr_nxt;
  logic [bcsr_pkg::ROW_IDX_W-1:0]    row_cnt_r, row_cnt_nxt;
  logic [bcsr_pkg::BLK_W-1:0]        rows_here_r;
  logic [bcsr_pkg::BLK_W-1:0]        blk_rows_r;
  logic [bcsr_pkg::POS_W-1:0]        col_idx_r;
  logic [bcsr_pkg::CNT_W-1:0]        ptr_val_r;

  logic                              vld_r, vld_nxt;
  logic [bcsr_pkg::KIND_W-1:0]       kind_r, kind_nxt;
  logic [bcsr_pkg::ROW_W-1:0]        lanes_r, lanes_nxt;
  logic [bcsr_pkg::CNT_W-1:0]        idx_r, idx_nxt;
  logic                              last_r, last_nxt;
  logic                              slot_free;

  assign busy      = lead_r | rows_r | col_r | ptr_r;
  assign buf_raddr = row_cnt_r;
  assign slot_free = !vld_r || out_tready;

  always_comb begin
    lead_nxt    = lead_r;
    rows_nxt    = rows_r;
    col_nxt     = col_r;
    ptr_nxt     = ptr_r;
    row_cnt_nxt = row_cnt_r;
    vld_nxt     = vld_r && !out_tready;
    kind_nxt    = kind_r;
    lanes_nxt   = lanes_r;
    idx_nxt     = idx_r;
    last_nxt    = last_r;
    if (slot_free && busy) begin
      vld_nxt   = 1'b1;
      lanes_nxt = '0;
      idx_nxt   = '0;
      priority if (lead_r) begin
        kind_nxt = bcsr_pkg::KIND_PTR;
        last_nxt = !(rows_r | col_r | ptr_r);
        lead_nxt = 1'b0;
      end else if (rows_r) begin
        kind_nxt = bcsr_pkg::KIND_VALUE;
        last_nxt = 1'b0;
        if ((bcsr_pkg::BLK_W)'(row_cnt_r) < rows_here_r) lanes_nxt = buf_rdata;
        if ((bcsr_pkg::BLK_W)'(row_cnt_r) == blk_rows_r - 1'b1) begin
          rows_nxt = 1'b0;
        end else begin
          row_cnt_nxt = row_cnt_r + 1'b1;
        end
      end else if (col_r) begin
        kind_nxt = bcsr_pkg::KIND_COL;
        idx_nxt  = bcsr_pkg::CNT_W'(col_idx_r);
        last_nxt = !ptr_r;
        col_nxt  = 1'b0;
      end else begin
        kind_nxt = bcsr_pkg::KIND_PTR;
        idx_nxt  = ptr_val_r;
        last_nxt = 1'b1;
        ptr_nxt  = 1'b0;
      end
    end
    if (req_load) begin
      lead_nxt    = req.lead_ptr;
      rows_nxt    = req.blk;
      col_nxt     = req.blk;
      ptr_nxt     = req.row_ptr;
      row_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r    <= 1'b0;
      rows_r    <= 1'b0;
      col_r     <= 1'b0;
      ptr_r     <= 1'b0;
      row_cnt_r <= '0;
      vld_r     <= 1'b0;
    end else begin
      lead_r    <= lead_nxt;
      rows_r    <= rows_nxt;
      col_r     <= col_nxt;
      ptr_r     <= ptr_nxt;
      row_cnt_r <= row_cnt_nxt;
      vld_r     <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    lanes_r <= lanes_nxt;
    idx_r   <= idx_nxt;
    last_r  <= last_nxt;
    if (req_load) begin
      rows_here_r <= req.rows_here;
      blk_rows_r  <= req.blk_rows;
      col_idx_r   <= req.col_idx;
      ptr_val_r   <= req.ptr_val;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {(bcsr_pkg::OUT_DATA_W - bcsr_pkg::ROW_W - bcsr_pkg::CNT_W)'(0),
                       idx_r, lanes_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

@@ rtl/bcsr_block_sparse_packer.sv @@
// Top level of the block sparse row packer: positions, lanes, row buffer, emitter.
//
//  channel  dir  handshake               payload
//  in_      in   in_tvalid/in_tready     in_tdata: lane_0..lane_7, row_zero_point
//  out_     out  out_tvalid/out_tready   out_tdata: lanes 0..7, index; tuser kind;
//                                        tlast last_of_run
//  cfg_     in   cfg_we                  cfg_index, cfg_wdata
//
// Each input beat is accepted, then passes the lane/merge step; any results
// (up to 11) go one at a time into the output register, and the next beat is
// accepted once the last is loaded. Reset (rst_n low at a clock edge) clears
// positions, counts and the control and config registers; the row buffer and
// data registers are not cleared and in_tready stays low. A stalled output
// holds its beat and stalls the emitter until out_tready returns.
module bcsr_block_sparse_packer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // lane_0..lane_7 from bit 0 up, then row_zero_point at [71:64]
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [bcsr_pkg::IN_DATA_W-1:0]       in_tdata,
  // out_lane_0..out_lane_7 from bit 0 up, out_index at [88:64], zero fill above
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bcsr_pkg::OUT_DATA_W-1:0]      out_tdata,
  // out_kind
  output logic [bcsr_pkg::KIND_W-1:0]          out_tuser,
  output logic                                 out_tlast,
  input  logic                                 cfg_we,
  input  logic [bcsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bcsr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  // configuration
  logic [bcsr_pkg::DIM_W-1:0]  mat_rows_r, mat_cols_r;
  logic [bcsr_pkg::BLK_W-1:0]  blk_rows_r, blk_cols_r;
  logic                        per_tensor_r;
  logic [bcsr_pkg::LANE_W-1:0] tensor_zp_r;

  logic [bcsr_pkg::DIM_W-1:0]  rows_cl, cols_cl;
  logic [bcsr_pkg::BLK_W-1:0]  rb_cl, cb_cl;

  // position state
  logic [1:0]                        state_r, state_nxt;
  logic [bcsr_pkg::POS_W-1:0]        rbp_r, rbp_nxt;
  logic [bcsr_pkg::POS_W-1:0]        cbp_r, cbp_nxt;
  logic [bcsr_pkg::ROW_IDX_W-1:0]    rib_r, rib_nxt;
  logic                              nz_r, nz_nxt;
  logic [bcsr_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                              started_r, started_nxt;

  // captured beat
  bcsr_pkg::lane_byte_t              lane_in_r [bcsr_pkg::NUM_LANES];
  logic [bcsr_pkg::LANE_W-1:0]       zp_r;

  logic [bcsr_pkg::ROW_W-1:0]        row_buf_r [bcsr_pkg::MAX_BLOCK_ROWS];

  logic                              accept;
  logic [bcsr_pkg::PROD_W-1:0]       rb_base, cb_base;
  logic [bcsr_pkg::PROD_W:0]         rows_left;
  logic [bcsr_pkg::BLK_W-1:0]        rows_here;
  logic [bcsr_pkg::ROW_IDX_W-1:0]    rib_sat;
  logic                              rb_over, cb_over;
  logic                              last_row, last_cb, last_rb, nz_new;

  bcsr_pkg::lane_byte_t              lane_out [bcsr_pkg::NUM_LANES];
  logic                              lane_nz  [bcsr_pkg::NUM_LANES];
  logic [bcsr_pkg::ROW_W-1:0]        row_word;
  logic                              any_nz;

  logic                              req_load;
  bcsr_pkg::emit_req_t               req;
  logic                              emit_busy;
  logic [bcsr_pkg::ROW_IDX_W-1:0]    buf_raddr;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_rows_r   <= bcsr_pkg::DIM_W'(1);
      mat_cols_r   <= bcsr_pkg::DIM_W'(1);
      blk_rows_r   <= bcsr_pkg::BLK_W'(1);
      blk_cols_r   <= bcsr_pkg::BLK_W'(1);
      per_tensor_r <= 1'b1;
      tensor_zp_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcsr_pkg::REG_MATRIX_ROWS: mat_rows_r   <= cfg_wdata[bcsr_pkg::DIM_W-1:0];
        bcsr_pkg::REG_MATRIX_COLS: mat_cols_r   <= cfg_wdata[bcsr_pkg::DIM_W-1:0];
        bcsr_pkg::REG_BLOCK_ROWS:  blk_rows_r   <= cfg_wdata[bcsr_pkg::BLK_W-1:0];
        bcsr_pkg::REG_BLOCK_COLS:  blk_cols_r   <= cfg_wdata[bcsr_pkg::BLK_W-1:0];
        bcsr_pkg::REG_PER_TENSOR:  per_tensor_r <= cfg_wdata[0];
        bcsr_pkg::REG_TENSOR_ZP:   tensor_zp_r  <= cfg_wdata[bcsr_pkg::LANE_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated view used by every beat
  assign rows_cl = bcsr_pkg::clamp_dim(mat_rows_r);
  assign cols_cl = bcsr_pkg::clamp_dim(mat_cols_r);
  assign rb_cl   = bcsr_pkg::clamp_blk(blk_rows_r, bcsr_pkg::BLK_W'(bcsr_pkg::MAX_BLOCK_ROWS));
  assign cb_cl   = bcsr_pkg::clamp_blk(blk_cols_r, bcsr_pkg::BLK_W'(bcsr_pkg::MAX_BLOCK_COLS));

  // ---------------- block geometry ----------------
  // Shared products: on the accept cycle they check the old position against
  // the current config; in the calc cycle they give the fixed block origin.
  assign rb_base = bcsr_pkg::PROD_W'(rbp_r) * bcsr_pkg::PROD_W'(rb_cl);
  assign cb_base = bcsr_pkg::PROD_W'(cbp_r) * bcsr_pkg::PROD_W'(cb_cl);
  assign rb_over = rb_base >= bcsr_pkg::PROD_W'(rows_cl);
  assign cb_over = cb_base >= bcsr_pkg::PROD_W'(cols_cl);

  assign rows_left = (bcsr_pkg::PROD_W+1)'(rows_cl) - {1'b0, rb_base};
  assign rows_here = (rows_left >= (bcsr_pkg::PROD_W+1)'(rb_cl)) ? rb_cl
                                                               : rows_left[bcsr_pkg::BLK_W-1:0];
  // a row beyond this block's rows finishes the block
  assign rib_sat   = (bcsr_pkg::BLK_W'(rib_r) >= rows_here)
                   ? bcsr_pkg::ROW_IDX_W'(rows_here - 1'b1) : rib_r;
  assign last_row  = (bcsr_pkg::BLK_W'(rib_sat) + 1'b1) >= rows_here;
  assign last_cb   = ({1'b0, cb_base} + (bcsr_pkg::PROD_W+1)'(cb_cl))
                     >= (bcsr_pkg::PROD_W+1)'(cols_cl);
  assign last_rb   = ({1'b0, rb_base} + (bcsr_pkg::PROD_W+1)'(rb_cl))
                     >= (bcsr_pkg::PROD_W+1)'(rows_cl);

  // ---------------- lanes and merge ----------------
  for (genvar j = 0; j < bcsr_pkg::NUM_LANES; j++) begin : g_lane
    bcsr_lane u_lane (
      .lane_val (lane_in_r[j]),
      .zero_pt  (zp_r),
      .col_base (cb_base),
      .lane_idx (bcsr_pkg::LANE_IDX_W'(j)),
      .blk_cols (cb_cl),
      .mat_cols (cols_cl),
      .lane_out (lane_out[j]),
      .lane_nz  (lane_nz[j])
    );
  end

  bcsr_merge u_merge (
    .lane_bytes (lane_out),
    .lane_nz    (lane_nz),
    .row_word   (row_word),
    .any_nz     (any_nz)
  );

  assign nz_new = nz_r | any_nz;

  // ---------------- control ----------------
  assign in_tready = (state_r == S_IDLE) && rst_n;
  assign accept    = in_tvalid && in_tready;
  assign req_load  = (state_r == S_CALC) && (!started_r || last_row);

  always_comb begin
    state_nxt   = state_r;
    rbp_nxt     = rbp_r;
    cbp_nxt     = cbp_r;
    rib_nxt     = rib_r;
    nz_nxt      = nz_r;
    cnt_nxt     = cnt_r;
    started_nxt = started_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CALC;
          // config may have moved under the old position
          if (rb_over) begin
            rbp_nxt = '0;
            cbp_nxt = '0;
            rib_nxt = '0;
            nz_nxt  = 1'b0;
          end else if (cb_over) begin
            cbp_nxt = '0;
            rib_nxt = '0;
            nz_nxt  = 1'b0;
          end
        end
      end
      S_CALC: begin
        state_nxt   = req_load ? S_EMIT : S_IDLE;
        started_nxt = 1'b1;
        if (!last_row) begin
          rib_nxt = rib_sat + 1'b1;
          nz_nxt  = nz_new;
        end else begin
          rib_nxt = '0;
          nz_nxt  = 1'b0;
          if (nz_new) cnt_nxt = cnt_r + 1'b1;
          if (!last_cb) begin
            cbp_nxt = cbp_r + 1'b1;
          end else begin
            cbp_nxt = '0;
            if (!last_rb) begin
              rbp_nxt = rbp_r + 1'b1;
            end else begin
              // end of matrix
              rbp_nxt     = '0;
              cnt_nxt     = '0;
              started_nxt = 1'b0;
            end
          end
        end
      end
      S_EMIT: begin
        if (!emit_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rbp_r     <= '0;
      cbp_r     <= '0;
      rib_r     <= '0;
      nz_r      <= 1'b0;
      cnt_r     <= '0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rbp_r     <= rbp_nxt;
      cbp_r     <= cbp_nxt;
      rib_r     <= rib_nxt;
      nz_r      <= nz_nxt;
      cnt_r     <= cnt_nxt;
      started_r <= started_nxt;
    end
  end

  // beat capture and row buffer (no reset)
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < bcsr_pkg::NUM_LANES; j++)
        lane_in_r[j] <= in_tdata[j*bcsr_pkg::LANE_W +: bcsr_pkg::LANE_W];
      zp_r <= per_tensor_r ? tensor_zp_r
                           : in_tdata[bcsr_pkg::ROW_W +: bcsr_pkg::LANE_W];
    end
    if (state_r == S_CALC) row_buf_r[rib_sat] <= row_word;
  end

  // ---------------- emitter ----------------
  always_comb begin
    req.lead_ptr  = !started_r;
    req.blk       = last_row && nz_new;
    req.row_ptr   = last_row && last_cb;
    req.rows_here = rows_here;
    req.blk_rows  = rb_cl;
    req.col_idx   = cbp_r;
    req.ptr_val   = (last_row && nz_new) ? cnt_r + 1'b1 : cnt_r;
  end

  bcsr_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_load   (req_load),
    .req        (req),
    .busy       (emit_busy),
    .buf_raddr  (buf_raddr),
    .buf_rdata  (row_buf_r[buf_raddr]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ tb/tb_bcsr_block_sparse_packer.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the block sparse row packer: directed and random matrices.
module tb_bcsr_block_sparse_packer;
  import bcsr_pkg::*;

  // Cycles with no handshake anywhere before the run is declared hung.
  localparam int QUIET_LIMIT     = 2000;
  // Rough number of row segments sent in the random part.
  localparam int RANDOM_SEGMENTS = 195;
  // A segment that completes nothing only needs its accept and calc steps; leave margin.
  localparam int IDLE_CYCLES     = 8;
  localparam int SETTLE_CYCLES   = 16;

  // One expected output beat.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  lanes;
    logic [CNT_W-1:0]  index;
    logic              last;
  } pack_beat_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  bcsr_block_sparse_packer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // lane_0..lane_7, row_zero_point
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // out_lane_0..out_lane_7, out_index
    .out_tuser  (out_tuser),   // out_kind
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the register file, as written (masked to register width).
  // Clamping to legal ranges happens on every segment, like the block does.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]  set_rows       = DIM_W'(1);
  logic [DIM_W-1:0]  set_cols       = DIM_W'(1);
  logic [BLK_W-1:0]  set_brows      = BLK_W'(1);
  logic [BLK_W-1:0]  set_bcols      = BLK_W'(1);
  logic              set_per_tensor = 1'b1;
  logic [LANE_W-1:0] set_tensor_zp  = '0;

  // Packing position and block state of the predictor.
  int                row_ix    = 0;     // row within current block
  int                cblk      = 0;     // column block position
  int                rblk      = 0;     // row block position
  logic              blk_hot   = 1'b0;  // current block has a nonzero lane
  logic [CNT_W-1:0]  blk_count = '0;    // running nonzero block count
  logic              lead_sent = 1'b0;  // leading zero pointer already out
  logic [ROW_W-1:0]  seg_buf [MAX_BLOCK_ROWS];

  pack_beat_t pending_beats[$];         // expected output beats, oldest first
  int         errors     = 0;
  int         quiet      = 0;
  bit         no_gaps    = 1'b0;        // burst stretches: no idling either side
  int         ready_hold = 0;

  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_beat(input logic [KIND_W-1:0] kind,
                                    input logic [ROW_W-1:0] lanes,
                                    input logic [CNT_W-1:0] index);
    pack_beat_t b;
    b.kind  = kind;
    b.lanes = lanes;
    b.index = index;
    b.last  = 1'b0;
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: takes one accepted row segment, advances the packing position
  // and queues every beat the segment causes. tlast goes on the final one.
  // ---------------------------------------------------------------------------
  task automatic predict_segment(input logic [ROW_W-1:0] lanes,
                                 input logic [LANE_W-1:0] rzp);
    int               nrows, ncols, brows, bcols, nrb, ncb, rows_here, cbase, first, j, r;
    logic [LANE_W-1:0] zp;
    logic [ROW_W-1:0]  seg_row;
    nrows = clamp_int(int'(set_rows), 1, MAX_DIM);
    ncols = clamp_int(int'(set_cols), 1, MAX_DIM);
    brows = clamp_int(int'(set_brows), 1, MAX_BLOCK_ROWS);
    bcols = clamp_int(int'(set_bcols), 1, MAX_BLOCK_COLS);
    nrb   = (nrows + brows - 1) / brows;
    ncb   = (ncols + bcols - 1) / bcols;
    first = pending_beats.size();

    // config changed under a matrix: restart what no longer fits
    if (rblk >= nrb) begin
      rblk    = 0;
      cblk    = 0;
      row_ix  = 0;
      blk_hot = 1'b0;
    end
    if (cblk >= ncb) begin
      cblk    = 0;
      row_ix  = 0;
      blk_hot = 1'b0;
    end
    rows_here = nrows - rblk * brows;
    if (rows_here > brows) rows_here = brows;
    if (row_ix >= rows_here) row_ix = rows_here - 1;

    // keep in-range lanes only; any of them off the zero point marks the block
    cbase   = cblk * bcols;
    zp      = set_per_tensor ? set_tensor_zp : rzp;
    seg_row = '0;
    for (j = 0; j < bcols; j++) begin
      if (cbase + j < ncols) begin
        seg_row[LANE_W*j +: LANE_W] = lanes[LANE_W*j +: LANE_W];
        if (lanes[LANE_W*j +: LANE_W] != zp) blk_hot = 1'b1;
      end
    end
    seg_buf[row_ix] = seg_row;

    if (!lead_sent) begin
      push_beat(KIND_PTR, '0, '0);
      lead_sent = 1'b1;
    end

    if (row_ix + 1 < rows_here) begin
      row_ix++;
    end else begin
      if (blk_hot) begin
        for (r = 0; r < brows; r++)
          push_beat(KIND_VALUE, (r < rows_here) ? seg_buf[r] : '0, '0);
        push_beat(KIND_COL, '0, CNT_W'(cblk));
        blk_count = blk_count + 1'b1;
      end
      blk_hot = 1'b0;
      row_ix  = 0;
      if (cblk + 1 < ncb) begin
        cblk++;
      end else begin
        // row block done: pointer carries the running count
        push_beat(KIND_PTR, '0, blk_count);
        cblk = 0;
        if (rblk + 1 < nrb) begin
          rblk++;
        end else begin
          // end of matrix, next segment opens a new one
          rblk      = 0;
          blk_count = '0;
          lead_sent = 1'b0;
        end
      end
    end

    if (pending_beats.size() > first)
      pending_beats[pending_beats.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Input side. tvalid stays up between back-to-back beats; it only drops when
  // a gap is taken, so it is never lowered and raised in one time step.
  // ---------------------------------------------------------------------------
  task automatic send_segment(input logic [ROW_W-1:0] lanes, input logic [LANE_W-1:0] rzp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rzp, lanes};
    do @(posedge clk); while (!in_tready);
    predict_segment(lanes, rzp);
  endtask

  // Drain everything, then give a silent segment time to finish.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_MATRIX_ROWS: set_rows       = val[DIM_W-1:0];
      REG_MATRIX_COLS: set_cols       = val[DIM_W-1:0];
      REG_BLOCK_ROWS:  set_brows      = val[BLK_W-1:0];
      REG_BLOCK_COLS:  set_bcols      = val[BLK_W-1:0];
      REG_PER_TENSOR:  set_per_tensor = val[0];
      REG_TENSOR_ZP:   set_tensor_zp  = val[LANE_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all six registers back to back while the block is idle.
  task automatic set_matrix(input logic [CFG_DATA_W-1:0] rows, input logic [CFG_DATA_W-1:0] cols,
                            input logic [CFG_DATA_W-1:0] brows,
                            input logic [CFG_DATA_W-1:0] bcols,
                            input logic [CFG_DATA_W-1:0] per_tensor,
                            input logic [CFG_DATA_W-1:0] tzp);
    wait_idle();
    write_reg(REG_MATRIX_ROWS, rows);
    write_reg(REG_MATRIX_COLS, cols);
    write_reg(REG_BLOCK_ROWS, brows);
    write_reg(REG_BLOCK_COLS, bcols);
    write_reg(REG_PER_TENSOR, per_tensor);
    write_reg(REG_TENSOR_ZP, tzp);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random ready runs and stalls, steady ready in burst stretches.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (no_gaps) begin
      out_tready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 9) < 6) begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 10);
    end else begin
      out_tready <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  // Scoreboard: every accepted beat against the oldest expectation.
  always @(posedge clk) begin
    pack_beat_t want;
    int         j;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat kind %0d tdata %h last %b",
                 $time, out_tuser, out_tdata, out_tlast);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (out_tuser !== want.kind) begin
          $display("%0t: kind mismatch exp %0d got %0d", $time, want.kind, out_tuser);
          errors++;
        end
        for (j = 0; j < NUM_LANES; j++) begin
          if (out_tdata[LANE_W*j +: LANE_W] !== want.lanes[LANE_W*j +: LANE_W]) begin
            $display("%0t: lane %0d mismatch exp %h got %h", $time, j,
                     want.lanes[LANE_W*j +: LANE_W], out_tdata[LANE_W*j +: LANE_W]);
            errors++;
          end
        end
        if (out_tdata[ROW_W +: CNT_W] !== want.index) begin
          $display("%0t: index mismatch exp %0d got %0d", $time, want.index,
                   out_tdata[ROW_W +: CNT_W]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: tlast mismatch exp %b got %b", $time, want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog on handshake activity.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: 1x1 matrix, per-tensor, zero point 0. Lanes past the
  // block width are junk and must not matter.
  task automatic test_reset_defaults();
    send_segment({{7{8'hFF}}, 8'h00}, 8'h00);   // zero block: pointers only
    send_segment({56'h0, 8'h80}, 8'h7F);        // nonzero block, new matrix
  endtask

  // One 8x8 block in per-row mode: the longest burst (11 beats), extreme
  // lane and zero-point values. Also fills every buffer row.
  task automatic test_full_block_extremes();
    set_matrix(13'd8, 13'd8, 13'd8, 13'd8, 13'd0, 13'd0);
    send_segment({8{8'h7F}}, 8'h80);
    send_segment({8{8'h80}}, 8'h7F);
    send_segment({8{8'h55}}, 8'h00);
    send_segment({8{8'hAA}}, 8'hFF);
    send_segment({8{8'h00}}, 8'h00);
    send_segment({8{8'hFF}}, 8'hFF);
    send_segment(64'h0807060504030201, 8'h55);
    send_segment({$urandom, $urandom}, 8'hAA);
  endtask

  // Blocks equal to their zero point are dropped; a lane past the last
  // matrix column differing from it does not count.
  task automatic test_zero_blocks();
    set_matrix(13'd2, 13'd5, 13'd2, 13'd3, 13'd0, 13'd0);
    send_segment({40'hDEADBEEF01, {3{8'h11}}}, 8'h11);
    send_segment({40'h0102030405, {3{8'hEE}}}, 8'hEE);
    send_segment({40'hFFFFFFFFFF, 8'h5A, {2{8'h11}}}, 8'h11);  // lane 2 is column 5
    send_segment({40'h0, 8'hA5, {2{8'hEE}}}, 8'hEE);
    // per-tensor zero point, row zero point ignored
    set_matrix(13'd1, 13'd3, 13'd1, 13'd3, 13'd1, 13'h080);
    send_segment({40'h123456789A, {3{8'h80}}}, 8'h00);
  endtask

  // Out-of-range register values saturate; config changes mid-matrix push
  // the column and then the row block position past the new counts.
  task automatic test_register_saturation();
    set_matrix(13'd0, 13'h1FFF, 13'd15, 13'd15, 13'd1, 13'h080);
    send_segment({$urandom, $urandom}, 8'($urandom));
    send_segment({$urandom, $urandom}, 8'($urandom));
    set_matrix(13'h1FFF, 13'd0, 13'd0, 13'd0, 13'd0, 13'h07F);
    send_segment({$urandom, $urandom}, 8'($urandom));
    send_segment({$urandom, $urandom}, 8'($urandom));
    set_matrix(13'd1, 13'd3, 13'd1, 13'd3, 13'd1, 13'd0);
    send_segment({$urandom, $urandom}, 8'($urandom));
  endtask

  // Block rows shrink in the middle of a block: the row position saturates
  // and the next segment completes the block over earlier rows.
  task automatic test_mid_block_change();
    set_matrix(13'd16, 13'd8, 13'd8, 13'd8, 13'd1, 13'd5);
    repeat (5) send_segment({$urandom, $urandom}, 8'($urandom));
    set_matrix(13'd16, 13'd8, 13'd4, 13'd8, 13'd1, 13'd5);
    send_segment({$urandom, $urandom}, 8'($urandom));
  endtask

  // Random matrices, mostly sent whole; some cut short and some with wild
  // register values (only a prefix of those is sent).
  task automatic test_random_matrices();
    int                    sent, total, count, k, j, nrows, ncols, bcols;
    logic [CFG_DATA_W-1:0] rows, cols, br, bc;
    logic [LANE_W-1:0]     rzp, zp;
    logic [ROW_W-1:0]      lanes;
    bit                    wild, flat_blk;
    sent     = 0;
    flat_blk = 1'b0;
    while (sent < RANDOM_SEGMENTS) begin
      wild = ($urandom_range(0, 9) == 0);
      if (wild) begin
        rows = $urandom_range(0, 1) ? 13'd0 : CFG_DATA_W'($urandom);
        cols = $urandom_range(0, 1) ? 13'd0 : CFG_DATA_W'($urandom);
        br   = CFG_DATA_W'($urandom_range(0, 15));
        bc   = CFG_DATA_W'($urandom_range(0, 15));
      end else begin
        rows = CFG_DATA_W'($urandom_range(1, 10));
        cols = CFG_DATA_W'($urandom_range(1, 16));
        br   = CFG_DATA_W'($urandom_range(1, MAX_BLOCK_ROWS));
        bc   = CFG_DATA_W'($urandom_range(1, MAX_BLOCK_COLS));
      end
      set_matrix(rows, cols, br, bc, CFG_DATA_W'($urandom_range(0, 1)),
                 CFG_DATA_W'($urandom_range(0, 255)));
      no_gaps = ($urandom_range(0, 4) == 0);

      nrows = clamp_int(int'(set_rows), 1, MAX_DIM);
      ncols = clamp_int(int'(set_cols), 1, MAX_DIM);
      bcols = clamp_int(int'(set_bcols), 1, MAX_BLOCK_COLS);
      total = nrows * ((ncols + bcols - 1) / bcols);
      count = total;
      if (wild || total > 80)
        count = $urandom_range(1, (total < 24) ? total : 24);
      else if (total > 1 && $urandom_range(0, 6) == 0)
        count = $urandom_range(1, total - 1);

      for (k = 0; k < count; k++) begin
        // a third of the blocks sit on the zero point
        if (row_ix == 0) flat_blk = ($urandom_range(0, 2) == 0);
        rzp = LANE_W'($urandom);
        zp  = set_per_tensor ? set_tensor_zp : rzp;
        for (j = 0; j < NUM_LANES; j++)
          lanes[LANE_W*j +: LANE_W] = (flat_blk && j < bcols) ? zp : LANE_W'($urandom);
        if (flat_blk && $urandom_range(0, 9) == 0)
          lanes[LANE_W*$urandom_range(0, NUM_LANES-1) +: LANE_W] = LANE_W'($urandom);
        send_segment(lanes, rzp);
      end
      sent += count;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_full_block_extremes();
    test_zero_blocks();
    test_register_saturation();
    test_mid_block_change();
    test_random_matrices();

    // drain, then allow settle time for anything unexpected to show up
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bcsr_pkg.sv
rtl/bcsr_lane.sv
rtl/bcsr_merge.sv
rtl/bcsr_emit.sv
rtl/bcsr_block_sparse_packer.sv
tb/tb_bcsr_block_sparse_packer.sv
